### hdl/kps_pkg.sv
`default_nettype none

package kps_pkg;

  localparam int unsigned MAX_PATTERN = 64;
  localparam longint unsigned MAX_TEXT = 64'd1048576;

  localparam int unsigned CMD_W = 2;
  localparam int unsigned CH_W = 8;
  localparam int unsigned MATCH_START_W = 20;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

  // Commands from the controller to the datapath. At most one is high in a cycle.
  typedef struct packed {
    logic clear;
    logic app_first;
    logic app_start;
    logic text_start;
    logic text_skip;
    logic walk;
    logic fin_app;
    logic fin_txt;
    logic emit;
  } kps_ctl_t;

  typedef struct packed {
    logic len_zero;
    logic len_full;
    logic walk_more;
    logic hit;
    logic out_free;
  } kps_sts_t;

endpackage

`default_nettype wire

### hdl/kps_ram.sv
`default_nettype none

module kps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/kps_ctrl.sv
`default_nettype none

module kps_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [kps_pkg::CMD_W-1:0]  in_cmd,
  output logic                            in_stall,
  input  wire kps_pkg::kps_sts_t          sts,
  output kps_pkg::kps_ctl_t               ctl
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_WALK_APP = 2'd1;
  localparam logic [1:0] S_WALK_TXT = 2'd2;
  localparam logic [1:0] S_EMIT     = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            kps_pkg::CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            kps_pkg::CMD_APPEND: begin
              if (sts.len_zero) begin
                ctl.app_first = 1'b1;
              end else if (!sts.len_full) begin
                ctl.app_start = 1'b1;
                state_nxt     = S_WALK_APP;
              end
            end
            kps_pkg::CMD_TEXT: begin
              if (sts.len_zero) begin
                ctl.text_skip = 1'b1;
              end else begin
                ctl.text_start = 1'b1;
                state_nxt      = S_WALK_TXT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK_APP: begin
        if (sts.walk_more) begin
          ctl.walk = 1'b1;
        end else begin
          ctl.fin_app = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_WALK_TXT: begin
        if (sts.walk_more) begin
          ctl.walk = 1'b1;
        end else begin
          ctl.fin_txt = 1'b1;
          state_nxt   = sts.hit ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/kps_dp.sv
`default_nettype none

module kps_dp #(
  parameter int unsigned     MAX_PATTERN = kps_pkg::MAX_PATTERN,
  parameter longint unsigned MAX_TEXT    = kps_pkg::MAX_TEXT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [kps_pkg::CH_W-1:0]          in_ch,
  input  wire kps_pkg::kps_ctl_t                 ctl,
  output kps_pkg::kps_sts_t                      sts,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [kps_pkg::MATCH_START_W-1:0]      out_match_start
);

  localparam int unsigned PTR_W   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_PATTERN);
  localparam int unsigned IDX_W   = $clog2(MAX_TEXT);
  localparam int unsigned SUM_W   = (IDX_W + 1 > PTR_W) ? IDX_W + 1 : PTR_W;
  localparam int unsigned MS_W    = kps_pkg::MATCH_START_W;
  localparam int unsigned EXT_W   = (SUM_W > MS_W) ? SUM_W : MS_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_TEXT - 64'd1);
  localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(MAX_PATTERN);

  logic [PTR_W-1:0]         len_r;
  logic [PTR_W-1:0]         build_r;
  logic [PTR_W-1:0]         match_r;
  logic [PTR_W-1:0]         j_r;
  logic [kps_pkg::CH_W-1:0] ch_r;
  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         cur_idx_r;
  logic [MS_W-1:0]          start_r;
  logic                     out_valid_r;

  logic [PTR_W-1:0]         rd_ptr;
  logic [PTR_W-1:0]         rd_prev;
  logic [kps_pkg::CH_W-1:0] pat_rdata;
  logic [PTR_W-1:0]         fail_rdata;
  logic                     pat_we;
  logic                     fail_we;
  logic [PTR_W-1:0]         fail_wdata;
  logic                     ch_eq;
  logic [PTR_W-1:0]         m_len;
  logic [SUM_W-1:0]         idx_plus;
  logic [SUM_W-1:0]         len_ext;
  logic [SUM_W-1:0]         start_diff;
  logic [EXT_W-1:0]         start_ext;

  // Next prefix length to probe: the saved pointer at the start of a beat,
  // then one failure link per cycle while the byte does not extend it.
  always_comb begin
    if (ctl.text_start) begin
      rd_ptr = match_r;
    end else if (ctl.app_start) begin
      rd_ptr = build_r;
    end else begin
      rd_ptr = fail_rdata;
    end
  end

  assign rd_prev    = rd_ptr - PTR_W'(1);
  assign pat_we     = ctl.app_first | ctl.app_start;
  assign fail_we    = ctl.app_first | ctl.fin_app;
  assign fail_wdata = ctl.app_first ? '0 : m_len;

  kps_ram #(
    .WIDTH (kps_pkg::CH_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (in_ch),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (pat_rdata)
  );

  kps_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_PATTERN)
  ) u_fail_ram (
    .clk   (clk),
    .we    (fail_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (fail_wdata),
    .raddr (rd_prev[ADDR_W-1:0]),
    .rdata (fail_rdata)
  );

  assign ch_eq = (pat_rdata == ch_r);
  assign m_len = ch_eq ? j_r + PTR_W'(1) : j_r;

  assign idx_plus   = SUM_W'(cur_idx_r) + SUM_W'(1);
  assign len_ext    = SUM_W'(len_r);
  assign start_diff = (idx_plus >= len_ext) ? idx_plus - len_ext : '0;
  assign start_ext  = EXT_W'(start_diff);

  assign sts.len_zero  = (len_r == '0);
  assign sts.len_full  = (len_r >= PTR_MAX);
  assign sts.walk_more = (j_r != '0) && !ch_eq;
  assign sts.hit       = (m_len >= len_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      build_r     <= '0;
      match_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        len_r   <= '0;
        build_r <= '0;
        match_r <= '0;
        idx_r   <= '0;
      end
      if (ctl.app_first) begin
        build_r <= '0;
        len_r   <= len_r + PTR_W'(1);
      end
      if (ctl.fin_app) begin
        build_r <= m_len;
        len_r   <= len_r + PTR_W'(1);
      end
      if (ctl.text_start || ctl.text_skip) begin
        if (idx_r < IDX_LAST) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      // The failure value of the last pattern byte is always build_r.
      if (ctl.fin_txt) begin
        match_r <= sts.hit ? build_r : m_len;
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.text_start || ctl.app_start) begin
      ch_r <= in_ch;
    end
    if (ctl.text_start || ctl.app_start || ctl.walk) begin
      j_r <= rd_ptr;
    end
    if (ctl.text_start) begin
      cur_idx_r <= idx_r;
    end
    if (ctl.fin_txt) begin
      start_r <= start_ext[MS_W-1:0];
    end
    if (ctl.emit) begin
      out_match_start <= start_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hdl/kmp_pattern_search.sv
// Streaming Knuth-Morris-Pratt matcher. Each beat carries a command and a byte:
// clear empties the pattern and restarts the text index, append adds a pattern
// byte and extends the failure table unless the pattern is full, and text feeds
// one text byte. Each text byte that completes the pattern produces one beat
// with the zero-based start index of the match; overlapping matches are
// reported. Clear, a first append, a text byte with an empty pattern and an
// append to a full pattern leave the input free. Any other append or text byte
// stalls the input while failure links are followed, because each probe is one
// registered read of the pattern and failure memories; a text byte that matches
// then loads the output register, waiting while that register is still stalled.
// Following links is amortized over the bytes.
`default_nettype none

module kmp_pattern_search #(
  parameter int unsigned     MAX_PATTERN = kps_pkg::MAX_PATTERN,
  parameter longint unsigned MAX_TEXT    = kps_pkg::MAX_TEXT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [kps_pkg::CMD_W-1:0]            in_cmd,
  input  wire logic [kps_pkg::CH_W-1:0]             in_ch,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [kps_pkg::MATCH_START_W-1:0]         out_match_start
);

  kps_pkg::kps_ctl_t ctl;
  kps_pkg::kps_sts_t sts;

  kps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  kps_dp #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .ctl             (ctl),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_start (out_match_start)
  );

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ctl))
    else $error("controller issued more than one datapath command");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> sts.out_free)
    else $error("result loaded while the output register still holds a beat");

  a_walk_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.walk |-> !sts.len_zero)
    else $error("failure link walk with an empty pattern");

  a_text_handled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd == kps_pkg::CMD_TEXT)
      |-> (ctl.text_start || ctl.text_skip))
    else $error("accepted text beat did not advance the text index");

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kps_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 200;

  // Predicts the start index of every full match and checks the block's
  // results against them in order.
  class match_scoreboard;
    logic [CH_W-1:0] pat_mem[MAX_PATTERN];
    logic [6:0]      link_mem[MAX_PATTERN];
    int unsigned     pat_len;
    int unsigned     build_ptr;
    int unsigned     match_ptr;
    longint unsigned text_pos;
    logic [MATCH_START_W-1:0] pending_starts[$];
    int unsigned     fails;

    function new();
      foreach (pat_mem[i]) begin
        pat_mem[i] = '0;
        link_mem[i] = '0;
      end
      pat_len = 0;
      build_ptr = 0;
      match_ptr = 0;
      text_pos = 0;
      fails = 0;
    endfunction

    // Follow failure links until the byte extends the prefix of length j.
    function int unsigned extend_prefix(int unsigned j, logic [CH_W-1:0] c);
      while (j > 0 && j < MAX_PATTERN && pat_mem[j] != c)
        j = 32'(link_mem[j-1]);
      if (j < MAX_PATTERN && pat_mem[j] == c)
        j++;
      return j;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    task take_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch);
      longint unsigned pos;
      longint unsigned start;
      case (cmd)
        CMD_CLEAR: begin
          pat_len = 0;
          build_ptr = 0;
          match_ptr = 0;
          text_pos = 0;
        end
        CMD_APPEND: begin
          if (pat_len < MAX_PATTERN) begin
            pat_mem[pat_len] = ch;
            build_ptr = (pat_len == 0) ? 0 : extend_prefix(build_ptr, ch);
            link_mem[pat_len] = build_ptr[6:0];
            pat_len++;
          end
        end
        CMD_TEXT: begin
          pos = text_pos;
          if (text_pos < MAX_TEXT - 1)
            text_pos++;
          if (pat_len != 0) begin
            match_ptr = extend_prefix(match_ptr, ch);
            if (match_ptr >= pat_len) begin
              start = (pos + 1 >= pat_len) ? pos + 1 - pat_len : 0;
              pending_starts = {pending_starts, start[MATCH_START_W-1:0]};
              match_ptr = 32'(link_mem[pat_len-1]);
            end
          end
        end
        default: ;
      endcase
    endtask

    task check_start(logic [MATCH_START_W-1:0] got);
      logic [MATCH_START_W-1:0] want;
      if (pending_starts.size() == 0) begin
        report($sformatf("match_start %0d with no match pending", got));
      end else begin
        want = pending_starts.pop_front();
        if (got !== want)
          report($sformatf("match_start %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd;
  logic [CH_W-1:0] in_ch;
  logic out_valid;
  logic out_stall;
  logic [MATCH_START_W-1:0] out_match_start;

  match_scoreboard sb;
  bit calm;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned stall_left;

  kmp_pattern_search dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_ch(in_ch),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_match_start(out_match_start)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function int unsigned pick_gap();
    int unsigned r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat
  // was taken, or, if a gap follows, with valid dropped after that gap.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch);
    int unsigned gap;
    in_valid = 1'b1;
    in_cmd = cmd;
    in_ch = ch;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sb.take_item(cmd, ch);
    if (cmd != CMD_UNUSED)
      items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      in_cmd = CMD_W'($urandom_range(0, 3));
      in_ch = CH_W'($urandom_range(0, 255));
      repeat (gap) @(negedge clk);
    end
  endtask

  function logic [CH_W-1:0] pick_sym(logic [CH_W-1:0] base, int unsigned spread);
    return base ^ CH_W'($urandom_range(0, spread));
  endfunction

  // One sequence of an optional clear, pattern and text with random content and a little noise.
  task automatic run_sequence();
    int unsigned plen;
    int unsigned tlen;
    int unsigned spread;
    int unsigned r;
    logic [CH_W-1:0] base;
    bit long_run;
    calm = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 99) < 75)
      send_beat(CMD_CLEAR, CH_W'($urandom_range(0, 255)));
    base = CH_W'($urandom_range(0, 255));
    long_run = ($urandom_range(0, 99) < 8);
    if (long_run) begin
      // Repeated byte: may fill the pattern store, and excess bytes are then dropped.
      plen = $urandom_range(60, 70);
      tlen = $urandom_range(70, 90);
      spread = 0;
    end else begin
      plen = $urandom_range(1, 6);
      tlen = $urandom_range(8, 40);
      spread = ($urandom_range(0, 3) == 0) ? 3 : 1;
    end
    repeat (plen) send_beat(CMD_APPEND, pick_sym(base, spread));
    repeat (tlen) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_beat(CMD_UNUSED, CH_W'($urandom_range(0, 255)));
      else if (r < 6)
        send_beat(CMD_TEXT, CH_W'($urandom_range(0, 255)));
      else if (r < 8)
        send_beat(CMD_APPEND, pick_sym(base, spread));
      else if (long_run && r < 12)
        send_beat(CMD_TEXT, base ^ 8'h01);
      else
        send_beat(CMD_TEXT, pick_sym(base, spread));
    end
  endtask

  // Result side: random stall with short and long runs and free stretches.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        case ($urandom_range(0, 9))
          0: begin
            out_stall = 1'b0;
            stall_left = $urandom_range(100, 300);
          end
          1, 2, 3, 4: begin
            out_stall = 1'b0;
            stall_left = $urandom_range(1, 15);
          end
          9: begin
            out_stall = 1'b1;
            stall_left = $urandom_range(10, 40);
          end
          default: begin
            out_stall = 1'b1;
            stall_left = $urandom_range(1, 3);
          end
        endcase
      end else begin
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_start(out_match_start);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("kmp_pattern_search test failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    calm = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_CLEAR;
    in_ch = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pattern, extreme bytes, overlapping matches, ignored
    // command, append in the middle of text, and a single-byte pattern.
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_APPEND, 8'hFF);
    send_beat(CMD_APPEND, 8'h00);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_UNUSED, 8'hA5);
    send_beat(CMD_TEXT, 8'hFF);
    send_beat(CMD_APPEND, 8'h42);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'h42);
    send_beat(CMD_TEXT, 8'h5A);
    send_beat(CMD_CLEAR, 8'hFF);
    send_beat(CMD_APPEND, 8'h80);
    send_beat(CMD_TEXT, 8'h80);
    send_beat(CMD_TEXT, 8'h80);
    send_beat(CMD_TEXT, 8'h7F);
    send_beat(CMD_TEXT, 8'h80);

    // Text with an empty pattern, then a two-byte pattern that matches twice.
    send_beat(CMD_CLEAR, 8'h00);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h62);
    send_beat(CMD_APPEND, 8'h61);
    send_beat(CMD_APPEND, 8'h62);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h62);
    send_beat(CMD_TEXT, 8'h61);
    send_beat(CMD_TEXT, 8'h62);
    send_beat(CMD_CLEAR, 8'h00);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS)
      run_sequence();
    in_valid = 1'b0;

    while (sb.pending_starts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0)
      $display("kmp_pattern_search test passed");
    else
      $display("kmp_pattern_search test failed");
    $finish;
  end

endmodule

`default_nettype wire
